>>> rtl/pcp_pkg.sv
// Package with the character codes, command codes and field widths of the plotter command parser.
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int RX_W            = 8;
    localparam int CMD_W           = 4;
    localparam int NUM_W           = 32;
    localparam int OUT_NUMS        = 4;
    localparam int DEF_NUM_ARGS    = 4;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [RX_W-1:0] CH_SPACE = 8'h20;
    localparam logic [RX_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [RX_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [RX_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [RX_W-1:0] CH_NINE  = 8'h39;
    localparam logic [RX_W-1:0] CH_I     = 8'h49;
    localparam logic [RX_W-1:0] CH_N     = 8'h4E;
    localparam logic [RX_W-1:0] CH_P     = 8'h50;
    localparam logic [RX_W-1:0] CH_C     = 8'h43;
    localparam logic [RX_W-1:0] CH_U     = 8'h55;
    localparam logic [RX_W-1:0] CH_A     = 8'h41;
    localparam logic [RX_W-1:0] CH_R     = 8'h52;
    localparam logic [RX_W-1:0] CH_D     = 8'h44;

    localparam logic [CMD_W-1:0] CMD_NONE     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INIT     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_WINDOW   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SCALE    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PEN_UP   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PLOT_ABS = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PLOT_REL = 4'd6;
    localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 4'd7;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN  = 4'd8;

    typedef logic [2:0] used_t;

endpackage

>>> rtl/plotter_command_parser.sv
// Top level of the plotter command parser: byte input register, parse logic and result register.
// The result register offers a beat once the ending ';' has passed the byte input register.
// Throughput: one byte per cycle; while a result beat waits, the byte behind it waits as well.
// A byte that ends no command produces no result beat.
// Reset clears both valid flags and all parse state, numbers included; the byte and result
// data registers are not reset.
`timescale 1ns / 1ps

module plotter_command_parser #(
    parameter int NUM_ARGS    = pcp_pkg::DEF_NUM_ARGS,
    parameter int VALUE_WIDTH = pcp_pkg::DEF_VALUE_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [pcp_pkg::RX_W-1:0]   rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pcp_pkg::CMD_W-1:0]  command,
    output logic signed [pcp_pkg::NUM_W-1:0] first_x,
    output logic signed [pcp_pkg::NUM_W-1:0] first_y,
    output logic signed [pcp_pkg::NUM_W-1:0] second_x,
    output logic signed [pcp_pkg::NUM_W-1:0] second_y
);
    import pcp_pkg::*;

    localparam int SW   = $clog2(NUM_ARGS + 1);
    localparam int IW   = $clog2(NUM_ARGS);
    localparam int KEEP = (NUM_ARGS < OUT_NUMS) ? NUM_ARGS : OUT_NUMS;

    logic                   in_valid_reg;
    logic [RX_W-1:0]        in_byte_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CMD_W-1:0]       command_reg;
    logic [NUM_W-1:0]       result_reg [OUT_NUMS];

    logic [RX_W-1:0]        lead_reg, lead_next;
    logic [RX_W-1:0]        op_reg, op_next;
    logic [1:0]             letters_reg, letters_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic                   in_digits_reg, in_digits_next;
    logic                   minus_reg, minus_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] numbers_reg [NUM_ARGS];
    logic [VALUE_WIDTH-1:0] numbers_next [NUM_ARGS];

    logic                   advance;
    logic                   keep;
    logic                   digit;
    logic                   finish;
    logic                   emit;
    logic [VALUE_WIDTH-1:0] digit_val;
    logic [VALUE_WIDTH-1:0] value;
    logic [CMD_W-1:0]       cmd_code;
    used_t                  used_count;
    logic [NUM_W-1:0]       result_next [OUT_NUMS];

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign first_x   = result_reg[0];
    assign first_y   = result_reg[1];
    assign second_x  = result_reg[2];
    assign second_y  = result_reg[3];

    always_comb
    begin
        keep      = (in_byte_reg > CH_SPACE) && !in_byte_reg[RX_W-1];
        digit     = in_byte_reg inside {[CH_ZERO:CH_NINE]};
        digit_val = VALUE_WIDTH'(in_byte_reg[3:0]);
        emit      = keep && (in_byte_reg == CH_SEMI);
        finish    = 1'b0;

        lead_next      = lead_reg;
        op_next        = op_reg;
        letters_next   = letters_reg;
        slot_next      = slot_reg;
        in_digits_next = in_digits_reg;
        minus_next     = minus_reg;
        acc_next       = acc_reg;
        numbers_next   = numbers_reg;

        if (keep)
        begin
            if (letters_reg < 2'd2)
            begin
                if (letters_reg == 2'd0)
                begin
                    lead_next = in_byte_reg;
                end
                else
                begin
                    op_next = in_byte_reg;
                end
                letters_next = letters_reg + 2'd1;
            end
            else if (in_byte_reg == CH_SEMI)
            begin
                finish = in_digits_reg && (slot_reg < SW'(NUM_ARGS));
            end
            else if (slot_reg < SW'(NUM_ARGS))
            begin
                if (!in_digits_reg)
                begin
                    if (in_byte_reg == CH_MINUS)
                    begin
                        minus_next = 1'b1;
                    end
                    else if (digit)
                    begin
                        acc_next = digit_val;
                    end
                    in_digits_next = 1'b1;
                end
                else if (digit)
                begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + digit_val;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
        end

        value = minus_reg ? (VALUE_WIDTH'(0) - acc_reg) : acc_reg;
        if (finish)
        begin
            numbers_next[slot_reg[IW-1:0]] = value;
            slot_next      = slot_reg + SW'(1);
            in_digits_next = 1'b0;
            minus_next     = 1'b0;
            acc_next       = '0;
        end

        used_count = used_t'(0);
        case (op_next)
            CH_N:    cmd_code = CMD_INIT;
            CH_P:
            begin
                if (lead_next == CH_I)
                begin
                    cmd_code   = CMD_WINDOW;
                    used_count = used_t'(4);
                end
                else
                begin
                    cmd_code = CMD_NONE;
                end
            end
            CH_C:
            begin
                cmd_code   = CMD_SCALE;
                used_count = used_t'(4);
            end
            CH_U:    cmd_code = CMD_PEN_UP;
            CH_A:
            begin
                cmd_code   = CMD_PLOT_ABS;
                used_count = used_t'(2);
            end
            CH_R:
            begin
                cmd_code   = CMD_PLOT_REL;
                used_count = used_t'(2);
            end
            CH_D:    cmd_code = CMD_PEN_DOWN;
            CH_SEMI: cmd_code = CMD_NONE;
            default: cmd_code = CMD_UNKNOWN;
        endcase

        for (int i = 0; i < OUT_NUMS; i++)
        begin
            result_next[i] = '0;
        end
        for (int i = 0; i < KEEP; i++)
        begin
            if (used_t'(i) < used_count)
            begin
                result_next[i] = NUM_W'(signed'(numbers_next[i]));
            end
        end

        if (emit)
        begin
            lead_next      = '0;
            op_next        = '0;
            letters_next   = '0;
            slot_next      = '0;
            in_digits_next = 1'b0;
            minus_next     = 1'b0;
            acc_next       = '0;
            for (int i = 0; i < NUM_ARGS; i++)
            begin
                numbers_next[i] = '0;
            end
        end

        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lead_reg      <= '0;
            op_reg        <= '0;
            letters_reg   <= '0;
            slot_reg      <= '0;
            in_digits_reg <= 1'b0;
            minus_reg     <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < NUM_ARGS; i++)
            begin
                numbers_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                lead_reg      <= lead_next;
                op_reg        <= op_next;
                letters_reg   <= letters_next;
                slot_reg      <= slot_next;
                in_digits_reg <= in_digits_next;
                minus_reg     <= minus_next;
                acc_reg       <= acc_next;
                numbers_reg   <= numbers_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && emit)
        begin
            command_reg <= cmd_code;
            result_reg  <= result_next;
        end
    end

endmodule

>>> tb/tb_plotter_command_parser.sv
// Self-checking testbench for the plotter command parser, with a byte-level command predictor.
`timescale 1ns / 1ps

module tb_plotter_command_parser;

    import pcp_pkg::*;

    localparam int SLOTS = DEF_NUM_ARGS;
    localparam logic [RX_W-1:0] CH_HIGH  = 8'h80;
    localparam logic [RX_W-1:0] CH_COMMA = 8'h2C;
    localparam int RANDOM_KEPT   = 1300;
    localparam int QUIET_FROM    = 1150;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 40;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_PRINTS    = 50;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [NUM_W-1:0] fx;
        logic [NUM_W-1:0] fy;
        logic [NUM_W-1:0] sx;
        logic [NUM_W-1:0] sy;
    } plot_cmd_t;

    class plot_cmd_scoreboard;
        logic [RX_W-1:0]  lead_letter;
        logic [RX_W-1:0]  op_letter;
        int               letters_seen;
        int               slot;
        logic             in_digits;
        logic             minus_seen;
        logic [NUM_W-1:0] acc;
        logic [NUM_W-1:0] nums [SLOTS];
        plot_cmd_t        pending_cmds [$];
        int               mismatches;
        int               checked;

        function new();
            mismatches = 0;
            checked    = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            lead_letter  = '0;
            op_letter    = '0;
            letters_seen = 0;
            slot         = 0;
            in_digits    = 1'b0;
            minus_seen   = 1'b0;
            acc          = '0;
            foreach (nums[k]) nums[k] = '0;
        endfunction

        function void end_number();
            if (slot < SLOTS) nums[slot] = minus_seen ? -acc : acc;
            slot++;
            in_digits  = 1'b0;
            minus_seen = 1'b0;
            acc        = '0;
        endfunction

        function void note_byte(input logic [RX_W-1:0] c);
            logic      is_digit;
            int        used;
            plot_cmd_t r;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (c <= CH_SPACE || c >= CH_HIGH) return;
            if (letters_seen < 2)
            begin
                if (letters_seen == 0) lead_letter = c;
                else op_letter = c;
                letters_seen++;
            end
            else if (c == CH_SEMI)
            begin
                if (in_digits && slot < SLOTS) end_number();
            end
            else if (slot < SLOTS)
            begin
                if (!in_digits)
                begin
                    if (c == CH_MINUS) minus_seen = 1'b1;
                    else if (is_digit) acc = {24'd0, c - CH_ZERO};
                    in_digits = 1'b1;
                end
                else if (is_digit)
                begin
                    acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
                end
                else
                begin
                    end_number();
                end
            end
            if (c != CH_SEMI) return;
            used = 0;
            case (op_letter)
                CH_N: r.cmd = CMD_INIT;
                CH_P:
                begin
                    if (lead_letter == CH_I)
                    begin
                        r.cmd = CMD_WINDOW;
                        used  = 4;
                    end
                    else
                    begin
                        r.cmd = CMD_NONE;
                    end
                end
                CH_C:
                begin
                    r.cmd = CMD_SCALE;
                    used  = 4;
                end
                CH_U: r.cmd = CMD_PEN_UP;
                CH_A:
                begin
                    r.cmd = CMD_PLOT_ABS;
                    used  = 2;
                end
                CH_R:
                begin
                    r.cmd = CMD_PLOT_REL;
                    used  = 2;
                end
                CH_D: r.cmd = CMD_PEN_DOWN;
                CH_SEMI: r.cmd = CMD_NONE;
                default: r.cmd = CMD_UNKNOWN;
            endcase
            r.fx = (used > 0) ? nums[0] : '0;
            r.fy = (used > 1) ? nums[1] : '0;
            r.sx = (used > 2) ? nums[2] : '0;
            r.sy = (used > 3) ? nums[3] : '0;
            pending_cmds.push_back(r);
            clear_parse();
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < MAX_PRINTS) $display("%0t: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(input plot_cmd_t got);
            plot_cmd_t want;
            if (pending_cmds.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat, command %0d", got.cmd));
            end
            else
            begin
                want = pending_cmds.pop_front();
                checked++;
                if (got.cmd !== want.cmd)
                    report_mismatch($sformatf("command %0d, wanted %0d", got.cmd, want.cmd));
                if (got.fx !== want.fx)
                    report_mismatch($sformatf("first_x %0d, wanted %0d",
                        $signed(got.fx), $signed(want.fx)));
                if (got.fy !== want.fy)
                    report_mismatch($sformatf("first_y %0d, wanted %0d",
                        $signed(got.fy), $signed(want.fy)));
                if (got.sx !== want.sx)
                    report_mismatch($sformatf("second_x %0d, wanted %0d",
                        $signed(got.sx), $signed(want.sx)));
                if (got.sy !== want.sy)
                    report_mismatch($sformatf("second_y %0d, wanted %0d",
                        $signed(got.sy), $signed(want.sy)));
            end
        endtask
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [RX_W-1:0]          rx_byte   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [CMD_W-1:0]         command;
    logic signed [NUM_W-1:0]  first_x;
    logic signed [NUM_W-1:0]  first_y;
    logic signed [NUM_W-1:0]  second_x;
    logic signed [NUM_W-1:0]  second_y;

    plot_cmd_scoreboard sb = new();
    logic gaps_on    = 1'b1;
    int   kept_bytes = 0;

    plotter_command_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .command   (command),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_byte(input logic [RX_W-1:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(b);
        if (b > CH_SPACE && b < CH_HIGH) kept_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_dropped();
        send_byte(RX_W'($urandom_range(0, 1) ? $urandom_range(0, 32)
                                             : $urandom_range(128, 255)));
    endtask

    // The receiver stalls in random bursts, and once holds off for a long stretch so that
    // the pipeline fills and the input side has to wait.
    initial
    begin
        int   stall_left;
        logic long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result('{command, first_x, first_y, second_x, second_y});
            if (stall_left > 0)
                stall_left--;
            else if (!long_hold_done && sb.checked >= HOLD_AFTER)
            begin
                stall_left     = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 19);
            out_ready <= (stall_left == 0);
        end
    end

    initial
    begin
        string op_pairs [9];
        int    kind;
        int    nargs;
        int    ndig;
        op_pairs = '{"IN", "IP", "SC", "PU", "PA", "PR", "PD", "XP", "IQ"};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_text(";;");
        send_text("I;");
        send_text("IN;");
        send_text("IP-9,1,2,3,4;");
        send_byte(8'h00);
        send_text("SC");
        send_byte(8'hFF);
        send_text("-;");
        send_text("PU;");
        send_text("PD;");
        send_byte(CH_SPACE);
        send_text("PA5;");
        send_byte(CH_HIGH);
        send_text("PR-,7;");
        send_byte(8'h7F);
        send_text("P;");
        send_text("ZQ1;");

        kept_bytes = 0;
        while (kept_bytes < RANDOM_KEPT)
        begin
            if (kept_bytes >= QUIET_FROM) gaps_on = 1'b0;
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 12)) send_byte(RX_W'($urandom_range(0, 255)));
                send_byte(CH_SEMI);
            end
            else
            begin
                if (kind == 1)
                begin
                    send_byte(RX_W'($urandom_range(33, 126)));
                    send_byte(RX_W'($urandom_range(33, 126)));
                end
                else
                begin
                    send_text(op_pairs[$urandom_range(0, 8)]);
                end
                nargs = $urandom_range(0, 6);
                for (int i = 0; i < nargs; i++)
                begin
                    if ($urandom_range(0, 3) == 0) send_byte(CH_MINUS);
                    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12)
                                                       : $urandom_range(1, 4);
                    repeat (ndig) send_byte(RX_W'(CH_ZERO + $urandom_range(0, 9)));
                    if ($urandom_range(0, 7) == 0) send_dropped();
                    if (i < nargs - 1 || $urandom_range(0, 1) == 0)
                        send_byte(RX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(33, 126)
                                                                    : CH_COMMA));
                end
                send_byte(CH_SEMI);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending_cmds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
rtl/pcp_pkg.sv
rtl/plotter_command_parser.sv
tb/tb_plotter_command_parser.sv
